[sv/kvs_pkg.sv]
// Shared constants for the chained hash key-value store: hash constants, default sizes,
// status codes, request modes and the remainder handshake type. No dependencies.
package kvs_pkg;

   // FNV-1a 32-bit constants
   localparam logic [31:0] HASH_BASIS = 32'd2166136261;
   localparam logic [31:0] HASH_PRIME = 32'd16777619;

   // Default sizes
   localparam int DEF_ENTRIES   = 256;
   localparam int DEF_BUCKETS   = 64;
   localparam int DEF_KEY_MAX   = 32;
   localparam int DEF_VALUE_MAX = 64;

   // Request modes
   localparam logic MODE_PUT = 1'b0;
   localparam logic MODE_GET = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ERR  = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   // Remainder unit handshake
   typedef struct packed {
      logic done;
      logic busy;
   } rem_stat_type;

endpackage

[sv/kvs_stream_if.sv]
// Valid/ready channel interfaces for request bytes and result words.
// No dependencies.
interface kvs_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;
   logic       key_end;
   logic       request_end;

   modport source (output valid, mode, data_byte, key_end, request_end, input ready);
   modport sink   (input valid, mode, data_byte, key_end, request_end, output ready);
endinterface

interface kvs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [1:0] status;
   logic       final_result;

   modport source (output valid, out_byte, byte_valid, status, final_result, input ready);
   modport sink   (input valid, out_byte, byte_valid, status, final_result, output ready);
endinterface

[sv/kvs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/kvs_bucket_rem.sv]
// Remainder of the 32-bit key hash by the bucket count, by reciprocal multiplication,
// with product, difference and slot registered in turn. Depends on kvs_pkg.
module kvs_bucket_rem #(
   parameter int BUCKETS = kvs_pkg::DEF_BUCKETS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                hash,
   output kvs_pkg::rem_stat_type      stat,
   output logic [$clog2(BUCKETS)-1:0] slot
);

   localparam int BW = $clog2(BUCKETS);
   localparam int SH = 31 + BW;
   // floor(2^SH / BUCKETS) stays below 2^32, so the quotient estimate is at most one low
   localparam logic [63:0] RECIP_W = (64'd1 << SH) / 64'(BUCKETS);
   localparam logic [31:0] RECIP   = RECIP_W[31:0];
   localparam logic [31:0] DIVISOR = 32'(BUCKETS);

   logic [31:0]   hkeep_ff;
   logic [63:0]   prod_ff, prod_in;
   logic [31:0]   diff_ff, diff_in;
   logic [BW-1:0] slot_ff, slot_in;
   logic          mul_ff, sub_ff, done_ff;
   logic [31:0]   quot, fix;

   // estimate the quotient, subtract its multiple, correct once
   always_comb begin
      prod_in = 64'(hash) * 64'(RECIP);
      quot    = 32'(prod_ff >> SH);
      diff_in = hkeep_ff - quot * DIVISOR;
      fix     = (diff_ff >= DIVISOR) ? diff_ff - DIVISOR : diff_ff;
      slot_in = fix[BW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= start;
         sub_ff  <= mul_ff;
         done_ff <= sub_ff;
      end
      if (start) begin
         hkeep_ff <= hash;
         prod_ff  <= prod_in;
      end
      if (mul_ff) begin
         diff_ff <= diff_in;
      end
      if (sub_ff) begin
         slot_ff <= slot_in;
      end
   end

   assign stat.done = done_ff;
   assign stat.busy = mul_ff | sub_ff;
   assign slot      = slot_ff;

endmodule

[sv/chained_hash_kv_store.sv]
// Chained hash key-value store engine.
// req_chan carries one request byte per word: key bytes (last flagged key_end), then
// value bytes for a put; request_end flags the final byte of the request. Words are
// taken one per cycle while a request is being received.
// rsp_chan returns result words: a put gives one final word with status; a get that
// hits a non-empty value gives one word per stored value byte, the last flagged
// final_result; an empty hit, a miss or an error gives one final word with status.
// After the request_end word the request is checked, the bucket remainder is taken
// and the bucket head is read; then each chain entry's metadata is read and its key
// compared byte by byte, and the result is decided. A new put then copies the key and
// the value into a free entry and writes its metadata (an overwrite copies only the
// value), and a get that hits reads out each value byte in turn. No new request byte
// is taken until the current request has been answered.
// After reset the bucket head memory is cleared, one bucket per cycle, and no word
// is taken meanwhile. A stalled rsp_chan holds the result register; the next
// request's bytes are still taken while a final word waits.
// Depends on kvs_pkg, kvs_stream_if, kvs_ram and kvs_bucket_rem.
module chained_hash_kv_store #(
   parameter int ENTRIES   = kvs_pkg::DEF_ENTRIES,
   parameter int BUCKETS   = kvs_pkg::DEF_BUCKETS,
   parameter int KEY_MAX   = kvs_pkg::DEF_KEY_MAX,
   parameter int VALUE_MAX = kvs_pkg::DEF_VALUE_MAX
) (
   input logic       clock,
   input logic       reset,
   kvs_req_if.sink   req_chan,
   kvs_rsp_if.source rsp_chan
);

   localparam int EW  = $clog2(ENTRIES + 1);
   localparam int EAW = $clog2(ENTRIES);
   localparam int BW  = $clog2(BUCKETS);
   localparam int KW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int KLW = $clog2(KEY_MAX + 1);
   localparam int VW  = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
   localparam int VLW = $clog2(VALUE_MAX + 1);
   localparam int CW  = (KLW > VLW) ? KLW : VLW;
   localparam int MW  = KLW + VLW + EW;
   localparam logic [EW-1:0] NULL_IDX = EW'(ENTRIES);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_RECV   = 4'd1;
   localparam logic [3:0] S_FIN    = 4'd2;
   localparam logic [3:0] S_MOD    = 4'd3;
   localparam logic [3:0] S_HEAD   = 4'd4;
   localparam logic [3:0] S_HEAD_D = 4'd5;
   localparam logic [3:0] S_WALK   = 4'd6;
   localparam logic [3:0] S_META_D = 4'd7;
   localparam logic [3:0] S_CMP    = 4'd8;
   localparam logic [3:0] S_DECIDE = 4'd9;
   localparam logic [3:0] S_COPYK  = 4'd10;
   localparam logic [3:0] S_COPYV  = 4'd11;
   localparam logic [3:0] S_META_W = 4'd12;
   localparam logic [3:0] S_GETR   = 4'd13;
   localparam logic [3:0] S_GETW   = 4'd14;
   localparam logic [3:0] S_RESP   = 4'd15;

   logic [3:0]     state_ff, state_in;
   logic [BW-1:0]  clr_ff, clr_in;
   logic [31:0]    hash_ff, hash_in;
   logic [KLW-1:0] kcnt_ff, kcnt_in;
   logic [VLW-1:0] vcnt_ff, vcnt_in;
   logic           err_ff, err_in;
   logic           inval_ff, inval_in;
   logic           mode_ff, mode_in;
   logic [BW-1:0]  slot_ff, slot_in;
   logic [EW-1:0]  idx_ff, idx_in;
   logic [EW-1:0]  head_ff, head_in;
   logic [EW-1:0]  link_ff, link_in;
   logic [VLW-1:0] vlen_ff, vlen_in;
   logic           found_ff, found_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [EW-1:0]  used_ff, used_in;
   logic [1:0]     status_ff, status_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_bv_ff, rsp_bv_in;
   logic [1:0] rsp_st_ff, rsp_st_in;
   logic       rsp_fin_ff, rsp_fin_in;

   logic       accept, out_free;
   logic [CW-1:0] cnt_nx, cnt_pv;

   // memory ports
   logic          bh_we, bh_re;
   logic [BW-1:0] bh_waddr, bh_raddr;
   logic [EW-1:0] bh_wdata, bh_rdata;
   logic          kb_we, kb_re;
   logic [KW-1:0] kb_waddr, kb_raddr;
   logic [7:0]    kb_rdata;
   logic          vb_we, vb_re;
   logic [VW-1:0] vb_waddr, vb_raddr;
   logic [7:0]    vb_rdata;
   logic          ek_we, ek_re;
   logic [EAW+KW-1:0] ek_waddr, ek_raddr;
   logic [7:0]    ek_rdata;
   logic          ev_we, ev_re;
   logic [EAW+VW-1:0] ev_waddr, ev_raddr;
   logic [7:0]    ev_rdata;
   logic          mt_we, mt_re;
   logic [EAW-1:0] mt_waddr, mt_raddr;
   logic [MW-1:0] mt_wdata, mt_rdata;
   logic [KLW-1:0] mt_klen;
   logic [VLW-1:0] mt_vlen;
   logic [EW-1:0]  mt_link;

   logic                  rem_start;
   kvs_pkg::rem_stat_type rem_stat;
   logic [BW-1:0]         rem_slot;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign cnt_nx   = cnt_ff + 1'b1;
   assign cnt_pv   = cnt_ff - 1'b1;
   assign {mt_klen, mt_vlen, mt_link} = mt_rdata;

   // request sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      hash_in   = hash_ff;
      kcnt_in   = kcnt_ff;
      vcnt_in   = vcnt_ff;
      err_in    = err_ff;
      inval_in  = inval_ff;
      mode_in   = mode_ff;
      slot_in   = slot_ff;
      idx_in    = idx_ff;
      head_in   = head_ff;
      link_in   = link_ff;
      vlen_in   = vlen_ff;
      found_in  = found_ff;
      cnt_in    = cnt_ff;
      used_in   = used_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_fin_in   = rsp_fin_ff;
      req_chan.ready = 1'b0;
      rem_start = 1'b0;
      bh_we = 1'b0; bh_waddr = slot_ff; bh_wdata = idx_ff;
      bh_re = 1'b0; bh_raddr = slot_ff;
      kb_we = 1'b0; kb_waddr = kcnt_ff[KW-1:0];
      kb_re = 1'b0; kb_raddr = cnt_ff[KW-1:0];
      vb_we = 1'b0; vb_waddr = vcnt_ff[VW-1:0];
      vb_re = 1'b0; vb_raddr = cnt_ff[VW-1:0];
      ek_we = 1'b0; ek_waddr = {idx_ff[EAW-1:0], cnt_pv[KW-1:0]};
      ek_re = 1'b0; ek_raddr = {idx_ff[EAW-1:0], cnt_ff[KW-1:0]};
      ev_we = 1'b0; ev_waddr = {idx_ff[EAW-1:0], cnt_pv[VW-1:0]};
      ev_re = 1'b0; ev_raddr = {idx_ff[EAW-1:0], cnt_ff[VW-1:0]};
      mt_we = 1'b0; mt_waddr = idx_ff[EAW-1:0];
      mt_wdata = {kcnt_ff, vcnt_ff, (found_ff ? link_ff : head_ff)};
      mt_re = 1'b0; mt_raddr = idx_ff[EAW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            // sweep every bucket head to empty
            bh_we    = 1'b1;
            bh_waddr = clr_ff;
            bh_wdata = NULL_IDX;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = S_RECV;
            end
         end
         S_RECV: begin
            // take request bytes, hash and buffer the key, buffer the value
            req_chan.ready = 1'b1;
            if (accept) begin
               if (!inval_ff) begin
                  if (kcnt_ff < KLW'(KEY_MAX)) begin
                     kb_we   = 1'b1;
                     kcnt_in = kcnt_ff + 1'b1;
                     hash_in = (hash_ff ^ {24'd0, req_chan.data_byte}) * kvs_pkg::HASH_PRIME;
                  end else begin
                     err_in = 1'b1;
                  end
                  if (req_chan.key_end) begin
                     inval_in = 1'b1;
                  end
               end else begin
                  if (vcnt_ff < VLW'(VALUE_MAX)) begin
                     vb_we   = 1'b1;
                     vcnt_in = vcnt_ff + 1'b1;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               if (req_chan.request_end) begin
                  mode_in  = req_chan.mode;
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (err_ff || kcnt_ff == '0) begin
               status_in = kvs_pkg::ST_ERR;
               state_in  = S_RESP;
            end else begin
               rem_start = 1'b1;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            if (rem_stat.done) begin
               slot_in  = rem_slot;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            bh_re    = 1'b1;
            state_in = S_HEAD_D;
         end
         S_HEAD_D: begin
            idx_in   = bh_rdata;
            head_in  = bh_rdata;
            state_in = S_WALK;
         end
         S_WALK: begin
            // end of chain means a miss
            if (idx_ff >= NULL_IDX) begin
               found_in = 1'b0;
               state_in = S_DECIDE;
            end else begin
               mt_re    = 1'b1;
               state_in = S_META_D;
            end
         end
         S_META_D: begin
            link_in = mt_link;
            vlen_in = mt_vlen;
            if (mt_klen != kcnt_ff) begin
               idx_in   = mt_link;
               state_in = S_WALK;
            end else begin
               ek_re    = 1'b1;
               ek_raddr = {idx_ff[EAW-1:0], {KW{1'b0}}};
               kb_re    = 1'b1;
               kb_raddr = '0;
               cnt_in   = '0;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // compare one key byte per cycle, fetch the next
            if (ek_rdata != kb_rdata) begin
               idx_in   = link_ff;
               state_in = S_WALK;
            end else if (CW'(kcnt_ff) == cnt_nx) begin
               found_in = 1'b1;
               state_in = S_DECIDE;
            end else begin
               ek_re    = 1'b1;
               ek_raddr = {idx_ff[EAW-1:0], cnt_nx[KW-1:0]};
               kb_re    = 1'b1;
               kb_raddr = cnt_nx[KW-1:0];
               cnt_in   = cnt_nx;
            end
         end
         S_DECIDE: begin
            cnt_in = '0;
            if (mode_ff == kvs_pkg::MODE_PUT) begin
               if (found_ff) begin
                  state_in = S_COPYV;
               end else if (used_ff == NULL_IDX) begin
                  status_in = kvs_pkg::ST_ERR;
                  state_in  = S_RESP;
               end else begin
                  idx_in   = used_ff;
                  state_in = S_COPYK;
               end
            end else begin
               if (!found_ff) begin
                  status_in = kvs_pkg::ST_MISS;
                  state_in  = S_RESP;
               end else if (vlen_ff == '0) begin
                  status_in = kvs_pkg::ST_OK;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_GETR;
               end
            end
         end
         S_COPYK: begin
            // read the key buffer, write each byte into the entry in the cycle after its read
            kb_re = (cnt_ff < CW'(kcnt_ff));
            ek_we = (cnt_ff != '0);
            if (cnt_ff == CW'(kcnt_ff)) begin
               cnt_in   = '0;
               state_in = S_COPYV;
            end else begin
               cnt_in = cnt_nx;
            end
         end
         S_COPYV: begin
            vb_re = (cnt_ff < CW'(vcnt_ff));
            ev_we = (cnt_ff != '0);
            if (cnt_ff == CW'(vcnt_ff)) begin
               state_in = S_META_W;
            end else begin
               cnt_in = cnt_nx;
            end
         end
         S_META_W: begin
            // lengths and link, and push a new entry onto its chain
            mt_we = 1'b1;
            if (!found_ff) begin
               bh_we   = 1'b1;
               used_in = used_ff + 1'b1;
            end
            status_in = kvs_pkg::ST_OK;
            state_in  = S_RESP;
         end
         S_GETR: begin
            ev_re    = 1'b1;
            state_in = S_GETW;
         end
         S_GETW: begin
            // hand one value byte to the result register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ev_rdata;
               rsp_bv_in    = 1'b1;
               rsp_st_in    = kvs_pkg::ST_OK;
               rsp_fin_in   = (cnt_nx == CW'(vlen_ff));
               if (cnt_nx == CW'(vlen_ff)) begin
                  state_in = S_RECV;
               end else begin
                  cnt_in   = cnt_nx;
                  state_in = S_GETR;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'd0;
               rsp_bv_in    = 1'b0;
               rsp_st_in    = status_ff;
               rsp_fin_in   = 1'b1;
               state_in     = S_RECV;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // drop the per-request state once the request is answered
      if (state_in == S_RECV && state_ff != S_RECV) begin
         hash_in  = kvs_pkg::HASH_BASIS;
         kcnt_in  = '0;
         vcnt_in  = '0;
         err_in   = 1'b0;
         inval_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         hash_ff      <= kvs_pkg::HASH_BASIS;
         kcnt_ff      <= '0;
         vcnt_ff      <= '0;
         err_ff       <= 1'b0;
         inval_ff     <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hash_ff      <= hash_in;
         kcnt_ff      <= kcnt_in;
         vcnt_ff      <= vcnt_in;
         err_ff       <= err_in;
         inval_ff     <= inval_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      head_ff     <= head_in;
      link_ff     <= link_in;
      vlen_ff     <= vlen_in;
      found_ff    <= found_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_bv_ff   <= rsp_bv_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_fin_ff  <= rsp_fin_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = rsp_byte_ff;
   assign rsp_chan.byte_valid   = rsp_bv_ff;
   assign rsp_chan.status       = rsp_st_ff;
   assign rsp_chan.final_result = rsp_fin_ff;

   kvs_bucket_rem #(.BUCKETS(BUCKETS)) u_rem (
      .clock (clock), .reset (reset), .start (rem_start), .hash (hash_ff),
      .stat  (rem_stat), .slot (rem_slot)
   );

   kvs_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_heads (
      .clock (clock), .we (bh_we), .waddr (bh_waddr), .wdata (bh_wdata),
      .re (bh_re), .raddr (bh_raddr), .rdata (bh_rdata)
   );

   kvs_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_key_buf (
      .clock (clock), .we (kb_we), .waddr (kb_waddr), .wdata (req_chan.data_byte),
      .re (kb_re), .raddr (kb_raddr), .rdata (kb_rdata)
   );

   kvs_ram #(.WIDTH(8), .DEPTH(VALUE_MAX)) u_val_buf (
      .clock (clock), .we (vb_we), .waddr (vb_waddr), .wdata (req_chan.data_byte),
      .re (vb_re), .raddr (vb_raddr), .rdata (vb_rdata)
   );

   kvs_ram #(.WIDTH(8), .DEPTH(ENTRIES << KW)) u_keys (
      .clock (clock), .we (ek_we), .waddr (ek_waddr), .wdata (kb_rdata),
      .re (ek_re), .raddr (ek_raddr), .rdata (ek_rdata)
   );

   kvs_ram #(.WIDTH(8), .DEPTH(ENTRIES << VW)) u_values (
      .clock (clock), .we (ev_we), .waddr (ev_waddr), .wdata (vb_rdata),
      .re (ev_re), .raddr (ev_raddr), .rdata (ev_rdata)
   );

   kvs_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta (
      .clock (clock), .we (mt_we), .waddr (mt_waddr), .wdata (mt_wdata),
      .re (mt_re), .raddr (mt_raddr), .rdata (mt_rdata)
   );

   // entry count never passes the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NULL_IDX) else $error("entry count beyond table size");

   // bucket heads change only in the clearing sweep or on an insert
   a_head_write: assert property (@(posedge clock) disable iff (reset)
      bh_we |-> (state_ff == S_CLEAR || state_ff == S_META_W))
      else $error("bucket head written outside sweep or insert");

   // request bytes are taken only while receiving
   a_ready_recv: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> state_ff == S_RECV) else $error("ready outside receive");

   // remainder completes only while it is awaited
   a_rem_done: assert property (@(posedge clock) disable iff (reset)
      rem_stat.done |-> state_ff == S_MOD) else $error("stray remainder result");

   // key count stays within the key buffer
   a_kcnt_bound: assert property (@(posedge clock) disable iff (reset)
      kcnt_ff <= KLW'(KEY_MAX)) else $error("key count overflow");

endmodule
